>>> hdl/cubic_bezier_tessellator_macros.svh
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator assertion macros
// Shared property shapes for the port checker.
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TESSELLATOR_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_MACROS_SVH

// same-cycle implication
`define CBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cbt_pkg.sv
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator package
// Shared constants and the control bundle that travels with each point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;
    localparam int CFG_W       = 16;
    localparam int NUM_CTRL    = 4;
    localparam logic [CFG_W-1:0] T_STEP_RESET = 16'd6554;

    typedef struct packed {
        logic valid;
        logic last;
    } cbt_ctl_t;

endpackage

`default_nettype wire

>>> hdl/cbt_seq.sv
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator point sequencer
// Holds a segment, steps t by t_step, evaluates once per cycle when enabled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbt_seq
    import cbt_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_W-1:0]              cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_x [NUM_CTRL],
    input  wire logic signed [COORD_WIDTH-1:0] in_y [NUM_CTRL],
    input  wire logic                          in_app,
    output cbt_ctl_t                           out_ctl,
    output logic [T_FRAC_BITS-1:0]             out_t,
    output logic signed [COORD_WIDTH-1:0]      out_x [NUM_CTRL],
    output logic signed [COORD_WIDTH-1:0]      out_y [NUM_CTRL]
);

    localparam int ACC_W = ((T_FRAC_BITS > CFG_W) ? T_FRAC_BITS : CFG_W) + 1;

    logic [CFG_W-1:0]              t_step_reg;
    logic                          busy_reg, busy_next;
    logic                          end_phase_reg, end_phase_next;
    logic                          app_reg;
    logic [ACC_W-1:0]              t_reg, t_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic signed [COORD_WIDTH-1:0] ctrl_x_reg [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] ctrl_y_reg [NUM_CTRL];
    cbt_ctl_t                      ctl_reg, ctl_next;
    logic [T_FRAC_BITS-1:0]        ot_reg;
    logic signed [COORD_WIDTH-1:0] ox_reg [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] oy_reg [NUM_CTRL];

    logic [ACC_W-1:0] t_sum;
    logic [CNT_W-1:0] n_inc;
    logic [CNT_W-1:0] cap;
    logic             curve_done;
    logic             issue_last;
    logic             load;

    always_comb begin
        t_sum      = t_reg + ACC_W'(t_step_reg);
        n_inc      = n_reg + CNT_W'(1);
        cap        = app_reg ? CNT_W'(MAX_RESULTS - 1) : CNT_W'(MAX_RESULTS);
        curve_done = ((t_sum >> T_FRAC_BITS) != '0) || (n_inc == cap);
        issue_last = end_phase_reg || (curve_done && !app_reg);
        in_ready   = !busy_reg || (en && issue_last);
        load       = in_valid && in_ready;

        busy_next      = busy_reg;
        end_phase_next = end_phase_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        ctl_next       = ctl_reg;

        if (en) begin
            ctl_next.valid = busy_reg;
            ctl_next.last  = busy_reg && issue_last;
            if (busy_reg) begin
                if (issue_last) begin
                    busy_next = 1'b0;
                end else if (curve_done) begin
                    end_phase_next = 1'b1;
                end else begin
                    t_next = t_sum;
                    n_next = n_inc;
                end
            end
        end

        if (load) begin
            busy_next      = 1'b1;
            end_phase_next = 1'b0;
            t_next         = '0;
            n_next         = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_step_reg    <= T_STEP_RESET;
            busy_reg      <= 1'b0;
            end_phase_reg <= 1'b0;
            t_reg         <= '0;
            n_reg         <= '0;
            ctl_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                t_step_reg <= cfg_wr_data;
            end
            busy_reg      <= busy_next;
            end_phase_reg <= end_phase_next;
            t_reg         <= t_next;
            n_reg         <= n_next;
            ctl_reg       <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            app_reg    <= in_app;
            ctrl_x_reg <= in_x;
            ctrl_y_reg <= in_y;
        end
        if (en && busy_reg) begin
            ot_reg <= end_phase_reg ? '0 : t_reg[T_FRAC_BITS-1:0];
            for (int i = 0; i < NUM_CTRL; i++) begin
                ox_reg[i] <= end_phase_reg ? ctrl_x_reg[NUM_CTRL-1] : ctrl_x_reg[i];
                oy_reg[i] <= end_phase_reg ? ctrl_y_reg[NUM_CTRL-1] : ctrl_y_reg[i];
            end
        end
    end

    assign out_ctl = ctl_reg;
    assign out_t   = ot_reg;
    assign out_x   = ox_reg;
    assign out_y   = oy_reg;

endmodule

`default_nettype wire

>>> hdl/cbt_lerp_level.sv
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator interpolation level
// One de Casteljau level: multiply stage, then shift and add stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbt_lerp_level
    import cbt_pkg::*;
#(
    parameter int N_IN        = 4,
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire cbt_ctl_t                      in_ctl,
    input  wire logic [T_FRAC_BITS-1:0]        in_t,
    input  wire logic signed [COORD_WIDTH-1:0] in_x [N_IN],
    input  wire logic signed [COORD_WIDTH-1:0] in_y [N_IN],
    output cbt_ctl_t                           out_ctl,
    output logic [T_FRAC_BITS-1:0]             out_t,
    output logic signed [COORD_WIDTH-1:0]      out_x [N_IN-1],
    output logic signed [COORD_WIDTH-1:0]      out_y [N_IN-1]
);

    localparam int N_OUT = N_IN - 1;
    localparam int PW    = COORD_WIDTH + T_FRAC_BITS + 2;

    cbt_ctl_t                      ctl1_reg, ctl2_reg;
    logic [T_FRAC_BITS-1:0]        t1_reg, t2_reg;
    logic signed [COORD_WIDTH-1:0] ax_reg [N_OUT];
    logic signed [COORD_WIDTH-1:0] ay_reg [N_OUT];
    logic signed [PW-1:0]          px_reg [N_OUT];
    logic signed [PW-1:0]          py_reg [N_OUT];
    logic signed [COORD_WIDTH-1:0] rx_reg [N_OUT];
    logic signed [COORD_WIDTH-1:0] ry_reg [N_OUT];

    logic signed [COORD_WIDTH:0]   dx [N_OUT];
    logic signed [COORD_WIDTH:0]   dy [N_OUT];
    logic signed [T_FRAC_BITS:0]   ts;
    logic signed [PW-1:0]          px [N_OUT];
    logic signed [PW-1:0]          py [N_OUT];
    logic signed [PW-1:0]          sx [N_OUT];
    logic signed [PW-1:0]          sy [N_OUT];
    logic signed [COORD_WIDTH-1:0] rx [N_OUT];
    logic signed [COORD_WIDTH-1:0] ry [N_OUT];

    always_comb begin
        ts = $signed({1'b0, in_t});
        for (int i = 0; i < N_OUT; i++) begin
            dx[i] = $signed({in_x[i+1][COORD_WIDTH-1], in_x[i+1]})
                  - $signed({in_x[i][COORD_WIDTH-1], in_x[i]});
            dy[i] = $signed({in_y[i+1][COORD_WIDTH-1], in_y[i+1]})
                  - $signed({in_y[i][COORD_WIDTH-1], in_y[i]});
            px[i] = PW'(dx[i]) * PW'(ts);
            py[i] = PW'(dy[i]) * PW'(ts);
        end
        for (int i = 0; i < N_OUT; i++) begin
            sx[i] = px_reg[i] >>> T_FRAC_BITS;
            sy[i] = py_reg[i] >>> T_FRAC_BITS;
            rx[i] = ax_reg[i] + sx[i][COORD_WIDTH-1:0];
            ry[i] = ay_reg[i] + sy[i][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= in_t;
            t2_reg <= t1_reg;
            for (int i = 0; i < N_OUT; i++) begin
                ax_reg[i] <= in_x[i];
                ay_reg[i] <= in_y[i];
                px_reg[i] <= px[i];
                py_reg[i] <= py[i];
                rx_reg[i] <= rx[i];
                ry_reg[i] <= ry[i];
            end
        end
    end

    assign out_ctl = ctl2_reg;
    assign out_t   = t2_reg;
    assign out_x   = rx_reg;
    assign out_y   = ry_reg;

endmodule

`default_nettype wire

>>> hdl/cubic_bezier_tessellator.sv
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator
// Evaluates one cubic segment at t = 0, t_step, 2*t_step, ... by de Casteljau.
// ---------------------------------------------------------------------------
// One input transaction carries a segment; it yields one output transaction per
// curve point, at most 64 in all, the final one flagged by m_tlast. The
// sequencer issues one point per cycle unless stalled, so a segment holds the
// input until its points are issued, and the next segment is taken in the cycle
// its predecessor issues its final point. Each point passes the sequencer
// register plus three interpolation levels of two stages each (multiply, then
// shift and add). Any stall on m_tready freezes the whole pipe.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_tessellator
    import cbt_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_W-1:0]              cfg_wr_data,  // t_step
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, handle_a_x, handle_a_y, handle_b_x, handle_b_y, end_x, end_y
    input  wire logic [8*COORD_WIDTH-1:0]      s_tdata,
    input  wire logic                          s_tuser,      // append_end
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // point_x, point_y, zero fill
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast       // last_point
);

    localparam int M_W = ((2*COORD_WIDTH+7)/8)*8;

    logic                          en;
    logic signed [COORD_WIDTH-1:0] in_x [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] in_y [NUM_CTRL];

    cbt_ctl_t                      c0_ctl, c1_ctl, c2_ctl, c3_ctl;
    logic [T_FRAC_BITS-1:0]        c0_t, c1_t, c2_t;
    logic signed [COORD_WIDTH-1:0] c0_x [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] c0_y [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] c1_x [NUM_CTRL-1];
    logic signed [COORD_WIDTH-1:0] c1_y [NUM_CTRL-1];
    logic signed [COORD_WIDTH-1:0] c2_x [NUM_CTRL-2];
    logic signed [COORD_WIDTH-1:0] c2_y [NUM_CTRL-2];
    logic signed [COORD_WIDTH-1:0] c3_x [1];
    logic signed [COORD_WIDTH-1:0] c3_y [1];

    always_comb begin
        for (int i = 0; i < NUM_CTRL; i++) begin
            in_x[i] = s_tdata[(2*i)*COORD_WIDTH +: COORD_WIDTH];
            in_y[i] = s_tdata[(2*i+1)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    assign en       = !c3_ctl.valid || m_tready;
    assign m_tvalid = c3_ctl.valid;
    assign m_tlast  = c3_ctl.last;
    assign m_tdata  = M_W'({c3_y[0], c3_x[0]});

    cbt_seq #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_app      (s_tuser),
        .out_ctl     (c0_ctl),
        .out_t       (c0_t),
        .out_x       (c0_x),
        .out_y       (c0_y)
    );

    cbt_lerp_level #(
        .N_IN        (NUM_CTRL),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lvl1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (c0_ctl),
        .in_t    (c0_t),
        .in_x    (c0_x),
        .in_y    (c0_y),
        .out_ctl (c1_ctl),
        .out_t   (c1_t),
        .out_x   (c1_x),
        .out_y   (c1_y)
    );

    cbt_lerp_level #(
        .N_IN        (NUM_CTRL-1),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lvl2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (c1_ctl),
        .in_t    (c1_t),
        .in_x    (c1_x),
        .in_y    (c1_y),
        .out_ctl (c2_ctl),
        .out_t   (c2_t),
        .out_x   (c2_x),
        .out_y   (c2_y)
    );

    cbt_lerp_level #(
        .N_IN        (NUM_CTRL-2),
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lvl3 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (c2_ctl),
        .in_t    (c2_t),
        .in_x    (c2_x),
        .in_y    (c2_y),
        .out_ctl (c3_ctl),
        .out_t   (),
        .out_x   (c3_x),
        .out_y   (c3_y)
    );

endmodule

`default_nettype wire

>>> hdl/cbt_checker.sv
// ---------------------------------------------------------------------------
// Cubic Bezier tessellator port checker
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_bezier_tessellator_macros.svh"

module cbt_checker #(
    parameter int COORD_WIDTH = 16
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic                          m_tlast
);

    // hold a stalled output transaction
    `CBT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // reset empties the pipe and frees the input
    `CBT_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid && s_tready, "not idle after reset")

    // every segment yields at least two points, so a new transaction blocks the input
    `CBT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after accept")

endmodule

bind cubic_bezier_tessellator cbt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbt_checker (.*);

`default_nettype wire
